// ===== hw/rtl/ptwk_pkg.sv =====
// Shared types, codes and constants for the polyphonic channel tweaker.
// No dependencies; every other file but ptwk_if.sv imports this package.
package ptwk_pkg;

    // Output channel limit and derived widths.
    localparam int MAX_CHANNELS = 16;
    localparam int SLOT_W       = 5;
    localparam int VOLT_W       = 16;
    // Working width for sums that can leave the 16-bit range.
    localparam int CALC_W       = 18;

    // 10 V in 1/2048 V units.
    localparam logic signed [CALC_W-1:0] UNIPOLAR_OFFSET = 18'sd20480;

    // Result queue depth; one item can push two results.
    localparam int RES_FIFO_DEPTH = 4;

    // Invert modes.
    localparam logic [1:0] INV_BIPOLAR  = 2'd0;
    localparam logic [1:0] INV_UNIPOLAR = 2'd1;
    localparam logic [1:0] INV_GATE     = 2'd2;

    // Result kinds.
    localparam logic KIND_CHANNEL   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_DISABLED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_SHAPING     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISABLE_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_HIGH_LEVEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_LOW_LEVEL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT       = 3'd7;

    // Configuration register file contents.
    typedef struct packed {
        logic [1:0]         invert_mode;
        logic               exclude_disabled;
        logic               gate_shaping;
        logic signed [15:0] disable_level;
        logic [14:0]        gate_threshold;
        logic [14:0]        gate_high_level;
        logic signed [15:0] gate_low_level;
        logic [14:0]        clip_limit;
    } cfg_t;

    // One input channel.
    typedef struct packed {
        logic signed [15:0] source_voltage;
        logic               source_present;
        logic signed [15:0] fill_voltage;
        logic signed [15:0] invert_gate;
        logic signed [15:0] disable_gate;
        logic signed [15:0] disable_offset;
        logic               frame_last;
    } item_t;

    // One result.
    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] out_voltage;
        logic [3:0]         out_slot;
        logic [4:0]         channel_count;
        logic               run_last;
    } result_t;

    // Everything the channel stage hands to the result queue.
    typedef struct packed {
        logic [1:0]          res_cnt;
        result_t [1:0]       res;
        logic [SLOT_W-1:0]   slot_next;
    } calc_out_t;

    // Sign-extend a 16-bit voltage to the working width.
    function automatic logic signed [CALC_W-1:0] sx16(input logic [15:0] v);
        sx16 = {{(CALC_W-16){v[15]}}, v};
    endfunction

    // Zero-extend a 15-bit magnitude to the working width.
    function automatic logic signed [CALC_W-1:0] zx15(input logic [14:0] v);
        zx15 = {{(CALC_W-15){1'b0}}, v};
    endfunction

endpackage

// ===== hw/rtl/ptwk_if.sv =====
// Valid/ready channel interfaces for input items and results.
// No dependencies; follows the package in compile order.
interface ptwk_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] source_voltage;
    logic               source_present;
    logic signed [15:0] fill_voltage;
    logic signed [15:0] invert_gate;
    logic signed [15:0] disable_gate;
    logic signed [15:0] disable_offset;
    logic               frame_last;

    modport source (
        output valid, source_voltage, source_present, fill_voltage,
               invert_gate, disable_gate, disable_offset, frame_last,
        input  ready
    );
    modport sink (
        input  valid, source_voltage, source_present, fill_voltage,
               invert_gate, disable_gate, disable_offset, frame_last,
        output ready
    );
endinterface

interface ptwk_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic signed [15:0] out_voltage;
    logic [3:0]         out_slot;
    logic [4:0]         channel_count;
    logic               run_last;

    modport source (
        output valid, result_kind, out_voltage, out_slot, channel_count, run_last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, out_voltage, out_slot, channel_count, run_last,
        output ready
    );
endinterface

// ===== hw/rtl/ptwk_channel_calc.sv =====
// Per-channel arithmetic and slot packing for one registered item.
// Depends on ptwk_pkg.
module ptwk_channel_calc
    import ptwk_pkg::*;
(
    input  cfg_t              cfg,
    input  item_t             item,
    input  logic [SLOT_W-1:0] slot,
    output calc_out_t         calc
);

    logic signed [CALC_W-1:0] thr;
    logic signed [CALC_W-1:0] lim;
    logic signed [CALC_W-1:0] hi_lvl;
    logic signed [CALC_W-1:0] lo_lvl;
    logic signed [CALC_W-1:0] v_sel;
    logic signed [CALC_W-1:0] v_shape;
    logic signed [CALC_W-1:0] v_inv;
    logic signed [CALC_W-1:0] v_raw;
    logic signed [CALC_W-1:0] v_clip;
    logic                     inv_hi;
    logic                     dis_hi;
    logic                     gate_mode;
    logic                     kept;
    logic                     emit_ch;
    logic                     fill_zero;
    logic [SLOT_W-1:0]        slot_a;
    result_t                  chan_res;
    result_t                  zero_res;
    result_t                  end_res;

    // Gate decisions and levels.
    assign thr       = zx15(cfg.gate_threshold);
    assign lim       = zx15(cfg.clip_limit);
    assign hi_lvl    = zx15(cfg.gate_high_level);
    assign lo_lvl    = sx16(cfg.gate_low_level);
    assign inv_hi    = sx16(item.invert_gate) >= thr;
    assign dis_hi    = sx16(item.disable_gate) >= thr;
    assign gate_mode = cfg.invert_mode >= INV_GATE;

    // Voltage path: select, shape, invert, choose by the disable and invert gates, then clip.
    always_comb
    begin
        v_sel = item.source_present ? sx16(item.source_voltage) : sx16(item.fill_voltage);

        if (gate_mode && cfg.gate_shaping)
        begin
            v_shape = (v_sel >= thr) ? hi_lvl : lo_lvl;
        end
        else
        begin
            v_shape = v_sel;
        end

        if (gate_mode)
        begin
            v_inv = (v_shape >= thr) ? lo_lvl : hi_lvl;
        end
        else if (cfg.invert_mode == INV_UNIPOLAR)
        begin
            v_inv = UNIPOLAR_OFFSET - v_shape;
        end
        else
        begin
            v_inv = -v_shape;
        end

        if (dis_hi)
        begin
            v_raw = sx16(cfg.disable_level) + sx16(item.disable_offset);
        end
        else if (inv_hi)
        begin
            v_raw = v_inv;
        end
        else
        begin
            v_raw = v_shape;
        end

        if (v_raw > lim)
        begin
            v_clip = lim;
        end
        else if (v_raw < -lim)
        begin
            v_clip = -lim;
        end
        else
        begin
            v_clip = v_raw;
        end
    end

    // Slot packing and frame-end bookkeeping.
    assign kept      = !(dis_hi && cfg.exclude_disabled);
    assign emit_ch   = kept && (slot < SLOT_W'(MAX_CHANNELS));
    assign slot_a    = slot + SLOT_W'(emit_ch);
    assign fill_zero = item.frame_last && (slot_a == '0);

    always_comb
    begin
        chan_res.result_kind   = KIND_CHANNEL;
        chan_res.out_voltage   = v_clip[15:0];
        chan_res.out_slot      = slot[3:0];
        chan_res.channel_count = '0;
        chan_res.run_last      = !item.frame_last;

        zero_res.result_kind   = KIND_CHANNEL;
        zero_res.out_voltage   = '0;
        zero_res.out_slot      = '0;
        zero_res.channel_count = '0;
        zero_res.run_last      = 1'b0;

        end_res.result_kind    = KIND_FRAME_END;
        end_res.out_voltage    = '0;
        end_res.out_slot       = '0;
        end_res.channel_count  = fill_zero ? 5'd1 : slot_a;
        end_res.run_last       = 1'b1;

        calc.res[1] = end_res;
        if (emit_ch)
        begin
            calc.res[0]  = chan_res;
            calc.res_cnt = item.frame_last ? 2'd2 : 2'd1;
        end
        else if (fill_zero)
        begin
            calc.res[0]  = zero_res;
            calc.res_cnt = 2'd2;
        end
        else
        begin
            calc.res[0]  = end_res;
            calc.res_cnt = item.frame_last ? 2'd1 : 2'd0;
        end

        calc.slot_next = item.frame_last ? '0 : slot_a;
    end

endmodule

// ===== hw/rtl/ptwk_result_fifo.sv =====
// Small result queue that takes up to two results per cycle and drives the
// output channel. Depends on ptwk_pkg and ptwk_out_if.
module ptwk_result_fifo
    import ptwk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  result_t [1:0]     push_data,
    output logic              room,
    ptwk_out_if.source        result
);

    localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RES_FIFO_DEPTH + 1);

    result_t              mem_reg [RES_FIFO_DEPTH];
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 pop;
    result_t              head;

    // Room for a full two-result push, judged on the registered count.
    assign room = cnt_reg <= CNT_W'(RES_FIFO_DEPTH - 2);
    assign pop  = result.valid && result.ready;
    assign head = mem_reg[rd_ptr_reg];

    assign result.valid         = cnt_reg != '0;
    assign result.result_kind   = head.result_kind;
    assign result.out_voltage   = head.out_voltage;
    assign result.out_slot      = head.out_slot;
    assign result.channel_count = head.channel_count;
    assign result.run_last      = head.run_last;

    // Pointer and occupancy update.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        cnt_next    = cnt_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage writes; the second result goes right behind the first.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push_data[1];
        end
    end

endmodule

// ===== hw/rtl/poly_channel_tweak_core.sv =====
// An accepted item is registered in the item stage, and its results are
// written to the result queue. Throughput: one item per cycle while each
// item yields at most one result and the queue has room; the output port
// moves one result per cycle, so two-result items can back up the queue.
// Reset: rst_n clears the slot count, the queue and the item stage, and
// loads the configuration registers with their reset values.
module poly_channel_tweak_core
    import ptwk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ptwk_in_if.sink              chan,
    ptwk_out_if.source           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cfg_t              cfg_reg;
    item_t             item_reg;
    logic              item_valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    calc_out_t         calc;
    logic              room;
    logic              advance;
    item_t             item_in;

    // Item stage handshake.
    assign advance    = item_valid_reg && room;
    assign chan.ready = !item_valid_reg || advance;

    assign item_in.source_voltage = chan.source_voltage;
    assign item_in.source_present = chan.source_present;
    assign item_in.fill_voltage   = chan.fill_voltage;
    assign item_in.invert_gate    = chan.invert_gate;
    assign item_in.disable_gate   = chan.disable_gate;
    assign item_in.disable_offset = chan.disable_offset;
    assign item_in.frame_last     = chan.frame_last;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_mode      <= INV_BIPOLAR;
            cfg_reg.exclude_disabled <= 1'b0;
            cfg_reg.gate_shaping     <= 1'b1;
            cfg_reg.disable_level    <= '0;
            cfg_reg.gate_threshold   <= 15'd2048;
            cfg_reg.gate_high_level  <= 15'd20480;
            cfg_reg.gate_low_level   <= '0;
            cfg_reg.clip_limit       <= 15'd32767;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INVERT_MODE:      cfg_reg.invert_mode      <= cfg_data[1:0];
                REG_EXCLUDE_DISABLED: cfg_reg.exclude_disabled <= cfg_data[0];
                REG_GATE_SHAPING:     cfg_reg.gate_shaping     <= cfg_data[0];
                REG_DISABLE_LEVEL:    cfg_reg.disable_level    <= cfg_data;
                REG_GATE_THRESHOLD:   cfg_reg.gate_threshold   <= cfg_data[14:0];
                REG_GATE_HIGH_LEVEL:  cfg_reg.gate_high_level  <= cfg_data[14:0];
                REG_GATE_LOW_LEVEL:   cfg_reg.gate_low_level   <= cfg_data;
                REG_CLIP_LIMIT:       cfg_reg.clip_limit       <= cfg_data[14:0];
                default:              cfg_reg.clip_limit       <= cfg_reg.clip_limit;
            endcase
        end
    end

    // Item stage and slot count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            slot_reg       <= '0;
        end
        else
        begin
            if (chan.ready)
            begin
                item_valid_reg <= chan.valid;
            end
            if (advance)
            begin
                slot_reg <= calc.slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chan.valid && chan.ready)
        begin
            item_reg <= item_in;
        end
    end

    // Channel arithmetic.
    ptwk_channel_calc u_calc (
        .cfg  (cfg_reg),
        .item (item_reg),
        .slot (slot_reg),
        .calc (calc)
    );

    // Result queue.
    ptwk_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (advance ? calc.res_cnt : 2'd0),
        .push_data (calc.res),
        .room      (room),
        .result    (result)
    );

endmodule

// ===== hw/rtl/ptwk_checker.sv =====
// Port-level checks on the result channel of poly_channel_tweak_core.
// Depends on ptwk_pkg; bound to the top level at the end of this file.
module ptwk_checker
    import ptwk_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_kind,
    input logic [15:0] res_voltage,
    input logic [3:0]  res_slot,
    input logic [4:0]  res_count,
    input logic        res_last
);

    // A frame always reports at least one and at most the maximum channels.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_FRAME_END
        |-> res_count != 5'd0 && res_count <= 5'(MAX_CHANNELS))
        else $error("frame end with bad channel count");

    // A frame end closes its item and carries no voltage or slot.
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_FRAME_END
        |-> res_last && res_voltage == 16'd0 && res_slot == 4'd0)
        else $error("frame end fields wrong");

    // Channel results never carry a count.
    a_chan_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_CHANNEL |-> res_count == 5'd0)
        else $error("channel result with nonzero count");

    // A channel result that is not the item's last is followed by a frame end.
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_kind == KIND_CHANNEL && !res_last
        |=> !res_valid || res_kind == KIND_FRAME_END)
        else $error("missing frame end after channel");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready
        |=> res_valid && $stable(res_voltage) && $stable(res_kind))
        else $error("stalled result changed");

endmodule

bind poly_channel_tweak_core ptwk_checker u_ptwk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_kind    (result.result_kind),
    .res_voltage (result.out_voltage),
    .res_slot    (result.out_slot),
    .res_count   (result.channel_count),
    .res_last    (result.run_last)
);
